>>> src/array_linked_list_engine_macros.svh
// assertion macros used by the port-level checker of the linked list engine
// no dependencies; every macro expects clk and arst_n in scope
`ifndef ARRAY_LINKED_LIST_ENGINE_MACROS_SVH
`define ARRAY_LINKED_LIST_ENGINE_MACROS_SVH

// plain property, sampled on clk, off during reset
`define ALLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ALLE_ASSERT_IMPL(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// next-cycle implication
`define ALLE_ASSERT_NEXT(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

>>> src/alle_pkg.sv
// shared types, widths and codes of the array linked list engine
// no dependencies; used by every module of the block except alle_ram
package alle_pkg;

	// field widths
	localparam int KIND_W   = 2;
	localparam int SLOT_W   = 5;
	localparam int DATA_W   = 64;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// default slot count, sentinel included (at most 2**SLOT_W)
	localparam int SLOTS_DEF = 32;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NEXT   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_PREV   = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	// result of one request, minus the stored value
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot_out;
		logic [COUNT_W-1:0]  count;
		logic                zero_data;
	} alle_res_t;

	// value store access for one request
	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} alle_mem_t;

endpackage

>>> src/alle_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module alle_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/alle_core.sv
// link state of the list: next/prev links, in-use flags, free chain head, count
// depends on alle_pkg; computes the result and state update of one request
module alle_core #(
	parameter int SLOTS = alle_pkg::SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [alle_pkg::KIND_W-1:0]  kind,
	input  logic [alle_pkg::SLOT_W-1:0]  slot,
	output alle_pkg::alle_res_t          res,
	output alle_pkg::alle_mem_t          mem
);

	localparam int IW = $clog2(SLOTS);

	logic [IW-1:0]                    next_link_q [SLOTS];
	logic [IW-1:0]                    prev_link_q [SLOTS];
	logic [SLOTS-1:0]                 in_use_q;
	logic [IW-1:0]                    free_head_q;
	logic [alle_pkg::COUNT_W-1:0]     count_q;

	logic [IW-1:0] si;
	logic          in_range;
	logic          slot_ok;
	logic          bad;
	logic          full;
	logic          is_insert;
	logic          is_delete;
	logic          is_nav;
	logic          do_ins;
	logic          do_del;
	logic          do_nav;
	logic [IW-1:0] nw;
	logic [IW-1:0] nx;
	logic [IW-1:0] pv;
	logic [IW-1:0] nb;

	// slot check and neighbor lookup
	always_comb begin
		si        = slot[IW-1:0];
		in_range  = (32'(slot) < SLOTS);
		slot_ok   = (slot == '0) || (in_range && in_use_q[si]);
		is_insert = (kind == alle_pkg::KIND_INSERT);
		is_delete = (kind == alle_pkg::KIND_DELETE);
		is_nav    = (kind == alle_pkg::KIND_NEXT) || (kind == alle_pkg::KIND_PREV);
		bad       = !slot_ok || (is_delete && slot == '0);
		full      = (count_q >= alle_pkg::COUNT_W'(SLOTS - 1));
		nw        = free_head_q;
		nx        = next_link_q[si];
		pv        = prev_link_q[si];
		nb        = (kind == alle_pkg::KIND_NEXT) ? nx : pv;
		do_ins    = !bad && is_insert && !full;
		do_del    = !bad && is_delete;
		do_nav    = !bad && is_nav;
	end

	// result fields
	always_comb begin
		if (bad) begin
			res.status = alle_pkg::ST_INVALID;
		end else if (is_insert && full) begin
			res.status = alle_pkg::ST_FULL;
		end else begin
			res.status = alle_pkg::ST_OK;
		end
		if (do_ins) begin
			res.slot_out = alle_pkg::SLOT_W'(nw);
		end else if (do_nav) begin
			res.slot_out = alle_pkg::SLOT_W'(nb);
		end else begin
			res.slot_out = slot;
		end
		if (do_ins) begin
			res.count = count_q + 1'b1;
		end else if (do_del) begin
			res.count = count_q - 1'b1;
		end else begin
			res.count = count_q;
		end
		res.zero_data = !do_nav || (nb == '0);
	end

	// value store: write new element on insert, read neighbor every step
	always_comb begin
		mem.we    = step && do_ins;
		mem.waddr = alle_pkg::SLOT_W'(nw);
		mem.re    = step;
		mem.raddr = alle_pkg::SLOT_W'(nb);
	end

	// link and free chain update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				next_link_q[i] <= (i == 0 || i + 1 >= SLOTS) ? '0 : IW'(i + 1);
				prev_link_q[i] <= '0;
			end
			in_use_q    <= '0;
			free_head_q <= IW'(1);
			count_q     <= '0;
		end else if (step) begin
			if (do_ins) begin
				free_head_q     <= next_link_q[nw];
				next_link_q[nw] <= nx;
				prev_link_q[nw] <= si;
				in_use_q[nw]    <= 1'b1;
				prev_link_q[nx] <= nw;
				next_link_q[si] <= nw;
			end
			if (do_del) begin
				next_link_q[pv] <= nx;
				prev_link_q[nx] <= pv;
				next_link_q[si] <= free_head_q;
				prev_link_q[si] <= '0;
				in_use_q[si]    <= 1'b0;
				free_head_q     <= si;
			end
			count_q <= res.count;
		end
	end

endmodule

>>> src/array_linked_list_engine.sv
// array linked list engine: request register, link logic, value ram, result register
// a taken request is registered, then moves on to the result register once that is free or being drained
// throughput: one request per cycle while results are drained; a stalled result holds back one request at most
// the value ram read (registered) lines up with the result register
// reset clears links, in-use flags, free chain and count; values stay unwritten
// depends on alle_pkg, alle_core and alle_ram
module array_linked_list_engine #(
	parameter int SLOTS = alle_pkg::SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [alle_pkg::KIND_W-1:0]    kind,
	input  logic [alle_pkg::SLOT_W-1:0]    slot,
	input  logic [alle_pkg::DATA_W-1:0]    data_in,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [alle_pkg::STATUS_W-1:0]  status,
	output logic [alle_pkg::SLOT_W-1:0]    slot_out,
	output logic [alle_pkg::DATA_W-1:0]    data_out,
	output logic [alle_pkg::COUNT_W-1:0]   count
);

	localparam int IW = $clog2(SLOTS);

	logic                          valid_s1;
	logic [alle_pkg::KIND_W-1:0]   kind_s1;
	logic [alle_pkg::SLOT_W-1:0]   slot_s1;
	logic [alle_pkg::DATA_W-1:0]   data_s1;
	logic                          valid_s2;
	alle_pkg::alle_res_t           res_s2;
	alle_pkg::alle_res_t           res;
	alle_pkg::alle_mem_t           mem;
	logic                          advance;
	logic [alle_pkg::DATA_W-1:0]   rdata;

	// request stage moves on when the result register is free or being drained
	assign advance   = valid_s1 && (!valid_s2 || res_ready);
	assign req_ready = !valid_s1 || advance;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			kind_s1 <= kind;
			slot_s1 <= slot;
			data_s1 <= data_in;
		end
	end

	// link state and request logic
	alle_core #(
		.SLOTS(SLOTS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.kind   (kind_s1),
		.slot   (slot_s1),
		.res    (res),
		.mem    (mem)
	);

	// element values
	alle_ram #(
		.WIDTH(alle_pkg::DATA_W),
		.DEPTH(SLOTS)
	) u_value_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr[IW-1:0]),
		.wdata (data_s1),
		.re    (mem.re),
		.raddr (mem.raddr[IW-1:0]),
		.rdata (rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	// result ports
	assign res_valid = valid_s2;
	assign status    = res_s2.status;
	assign slot_out  = res_s2.slot_out;
	assign count     = res_s2.count;
	assign data_out  = res_s2.zero_data ? '0 : rdata;

endmodule

>>> src/alle_checker.sv
// port-level checks of the array linked list engine, bound to the top level
// depends on alle_pkg and array_linked_list_engine_macros.svh
`include "array_linked_list_engine_macros.svh"

module alle_checker #(
	parameter int SLOTS = alle_pkg::SLOTS_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic [alle_pkg::STATUS_W-1:0]  status,
	input logic [alle_pkg::SLOT_W-1:0]    slot_out,
	input logic [alle_pkg::DATA_W-1:0]    data_out,
	input logic [alle_pkg::COUNT_W-1:0]   count
);

	logic [alle_pkg::COUNT_W-1:0] last_count_q;

	// element count seen in the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q <= '0;
		end else if (res_valid && res_ready) begin
			last_count_q <= count;
		end
	end

	// a stalled result keeps its payload
	`ALLE_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(status) && $stable(slot_out) && $stable(data_out) && $stable(count), "result changed while stalled")

	// each request moves the count by one step at most
	`ALLE_ASSERT_IMPL(a_count_step, res_valid, count == last_count_q || count == last_count_q + 1'b1 || count == last_count_q - 1'b1, "count jumped")

	// a rejected request leaves the count alone
	`ALLE_ASSERT_IMPL(a_reject_count, res_valid && status != alle_pkg::ST_OK, count == last_count_q, "rejected request changed count")

	// full is reported only at capacity, with zero data
	`ALLE_ASSERT_IMPL(a_full_cap, res_valid && status == alle_pkg::ST_FULL, count == alle_pkg::COUNT_W'(SLOTS - 1) && data_out == '0, "full reported below capacity")

endmodule

bind array_linked_list_engine alle_checker #(
	.SLOTS(SLOTS)
) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.status    (status),
	.slot_out  (slot_out),
	.data_out  (data_out),
	.count     (count)
);

>>> tb/tb_array_linked_list_engine.sv
// self-checking testbench for the array linked list engine (valid/ready on both sides)
// keeps its own copy of the slot links, free chain and values to predict every result
// depends on alle_pkg and array_linked_list_engine
module tb_array_linked_list_engine;
	import alle_pkg::*;

	localparam int NSLOT           = SLOTS_DEF;
	localparam int RANDOM_REQUESTS = 750;
	localparam int CYCLE_LIMIT     = 400000;

	typedef struct packed {
		logic [KIND_W-1:0] op;
		logic [SLOT_W-1:0] at;
		logic [DATA_W-1:0] value;
	} list_request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot_out;
		logic [DATA_W-1:0]   data_out;
		logic [COUNT_W-1:0]  count;
	} list_result_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	logic [KIND_W-1:0]   kind      = '0;
	logic [SLOT_W-1:0]   slot      = '0;
	logic [DATA_W-1:0]   data_in   = '0;
	logic                res_valid;
	logic                res_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_out;
	logic [DATA_W-1:0]   data_out;
	logic [COUNT_W-1:0]  count;

	// shadow of the list: links, free chain, values, element count
	logic [SLOT_W-1:0] next_lnk [NSLOT];
	logic [SLOT_W-1:0] prev_lnk [NSLOT];
	logic              live     [NSLOT];
	logic [DATA_W-1:0] vals     [NSLOT];
	logic [SLOT_W-1:0] free_hd;
	int                n_elems;

	list_request_t queued_requests [$];
	list_result_t  awaited_results [$];

	logic        req_acc = 1'b0;
	logic        calm    = 1'b0;
	int          req_gap = 0;
	int          ready_hold = 0;
	int          mismatches = 0;
	int          results_seen = 0;
	int          kind_seen [4];
	int          status_seen [3];
	int          peak_elems = 0;
	int unsigned cycles_run = 0;

	array_linked_list_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.kind      (kind),
		.slot      (slot),
		.data_in   (data_in),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.status    (status),
		.slot_out  (slot_out),
		.data_out  (data_out),
		.count     (count)
	);

	// clock, period 10
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow list after reset: empty ring, free chain 1 -> 2 -> ... -> last
	task automatic clear_list();
		for (int i = 0; i < NSLOT; i++) begin
			next_lnk[i] = (i == 0 || i + 1 >= NSLOT) ? '0 : SLOT_W'(i + 1);
			prev_lnk[i] = '0;
			live[i]     = 1'b0;
			vals[i]     = '0;
		end
		free_hd = SLOT_W'(1);
		n_elems = 0;
		for (int i = 0; i < 4; i++) kind_seen[i] = 0;
		for (int i = 0; i < 3; i++) status_seen[i] = 0;
	endtask

	// apply one request to the shadow list and work out its result
	task automatic step_list(input list_request_t rq, output list_result_t rs);
		logic [SLOT_W-1:0] s, nw, nx, pv, nb;
		s = rq.at;
		rs.status   = ST_OK;
		rs.slot_out = s;
		rs.data_out = '0;
		if (!(s == 0 || live[s]) || (rq.op == KIND_DELETE && s == 0)) begin
			rs.status = ST_INVALID;
		end else if (rq.op == KIND_INSERT) begin
			if (n_elems >= NSLOT - 1) begin
				rs.status = ST_FULL;
			end else begin
				nw = free_hd;
				nx = next_lnk[s];
				free_hd = next_lnk[nw];
				next_lnk[nw] = nx;
				prev_lnk[nw] = s;
				vals[nw] = rq.value;
				live[nw] = 1'b1;
				prev_lnk[nx] = nw;
				next_lnk[s] = nw;
				n_elems++;
				rs.slot_out = nw;
			end
		end else if (rq.op == KIND_DELETE) begin
			nx = next_lnk[s];
			pv = prev_lnk[s];
			next_lnk[pv] = nx;
			prev_lnk[nx] = pv;
			next_lnk[s] = free_hd;
			prev_lnk[s] = '0;
			live[s] = 1'b0;
			free_hd = s;
			n_elems--;
		end else begin
			nb = (rq.op == KIND_NEXT) ? next_lnk[s] : prev_lnk[s];
			rs.slot_out = nb;
			rs.data_out = (nb == 0) ? '0 : vals[nb];
		end
		rs.count = COUNT_W'(n_elems);
	endtask

	task automatic queue_request(input logic [KIND_W-1:0] op, input int at,
			input logic [DATA_W-1:0] value);
		list_request_t rq;
		rq.op    = op;
		rq.at    = SLOT_W'(at);
		rq.value = value;
		queued_requests.push_back(rq);
	endtask

	// mostly short gaps, a few long ones, none at all while calm
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// a slot in use most of the time, sometimes the sentinel, sometimes anything
	function automatic logic [SLOT_W-1:0] pick_slot();
		logic [SLOT_W-1:0] used [$];
		int r;
		for (int i = 1; i < NSLOT; i++)
			if (live[i]) used.push_back(SLOT_W'(i));
		r = $urandom_range(0, 99);
		if (r < 8) return SLOT_W'($urandom_range(0, NSLOT - 1));
		if (r < 18 || used.size() == 0) return '0;
		return used[$urandom_range(0, used.size() - 1)];
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return '0;
		if (r < 10) return '1;
		return {$urandom, $urandom};
	endfunction

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// request driver: new request or gap once the current one is taken
	always @(negedge clk) begin
		list_request_t rq;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_acc) begin
			if (req_gap > 0) begin
				req_gap--;
				req_valid <= 1'b0;
			end else if (queued_requests.size() != 0) begin
				rq = queued_requests.pop_front();
				kind      <= rq.op;
				slot      <= rq.at;
				data_in   <= rq.value;
				req_valid <= 1'b1;
				req_gap   = pick_gap();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (ready_hold > 0) begin
			ready_hold--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
			ready_hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
		end
	end

	// monitor: check results first, then predict for a newly taken request
	always @(posedge clk) begin
		list_request_t rq;
		list_result_t  rs;
		if (!arst_n) begin
			req_acc <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected, actual status %0d slot %0d",
						$time, status, slot_out);
				end else begin
					rs = awaited_results.pop_front();
					check_field("status", DATA_W'(rs.status), DATA_W'(status));
					check_field("slot_out", DATA_W'(rs.slot_out), DATA_W'(slot_out));
					check_field("data_out", rs.data_out, data_out);
					check_field("count", DATA_W'(rs.count), DATA_W'(count));
				end
			end
			req_acc <= req_valid && req_ready;
			if (req_valid && req_ready) begin
				rq.op    = kind;
				rq.at    = slot;
				rq.value = data_in;
				step_list(rq, rs);
				awaited_results.push_back(rs);
				kind_seen[rq.op]++;
				status_seen[rs.status]++;
				if (n_elems > peak_elems) peak_elems = n_elems;
			end
		end
	end

	// stimulus
	initial begin
		bit filling;
		int made, batch, r;
		logic [KIND_W-1:0] op;
		clear_list();
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// empty list, invalid slots, delete of the sentinel
		queue_request(KIND_NEXT, 0, '1);
		queue_request(KIND_PREV, 0, '0);
		queue_request(KIND_INSERT, 5, 64'h1);
		queue_request(KIND_DELETE, 0, '0);
		queue_request(KIND_NEXT, 31, '0);
		queue_request(KIND_PREV, 17, '0);
		// build a short ring with extreme values
		queue_request(KIND_INSERT, 0, '1);
		queue_request(KIND_INSERT, 0, '0);
		queue_request(KIND_INSERT, 1, 64'h8000_0000_0000_0001);
		queue_request(KIND_INSERT, 3, 64'h5555_5555_5555_5555);
		queue_request(KIND_INSERT, 2, 64'haaaa_aaaa_aaaa_aaaa);
		// walk both ways, wrapping through the sentinel
		queue_request(KIND_NEXT, 0, '0);
		queue_request(KIND_NEXT, 4, '0);
		queue_request(KIND_PREV, 0, '0);
		queue_request(KIND_PREV, 2, '0);
		queue_request(KIND_NEXT, 5, '0);
		// delete, touch the freed slot, reuse it from the free chain
		queue_request(KIND_DELETE, 1, '0);
		queue_request(KIND_NEXT, 1, '0);
		queue_request(KIND_DELETE, 1, '0);
		queue_request(KIND_INSERT, 4, 64'h0123_4567_89ab_cdef);
		queue_request(KIND_PREV, 1, '0);
		queue_request(KIND_DELETE, 4, '0);
		queue_request(KIND_DELETE, 2, '0);
		queue_request(KIND_NEXT, 0, '0);

		// random part: fill and drain phases so the list swings between empty and full
		made = 0;
		filling = 1'b1;
		while (made < RANDOM_REQUESTS) begin
			while (queued_requests.size() != 0) @(posedge clk);
			if (n_elems >= NSLOT - 1 && $urandom_range(0, 2) == 0) filling = 1'b0;
			else if (n_elems == 0) filling = 1'b1;
			else if ($urandom_range(0, 49) == 0) filling = !filling;
			calm = ($urandom_range(0, 7) == 0);
			batch = $urandom_range(1, 12);
			for (int i = 0; i < batch; i++) begin
				r = $urandom_range(0, 99);
				if (r < 55) op = filling ? KIND_INSERT : KIND_DELETE;
				else if (r < 70) op = filling ? KIND_DELETE : KIND_INSERT;
				else if (r < 85) op = KIND_NEXT;
				else op = KIND_PREV;
				queue_request(op, pick_slot(), pick_value());
			end
			made += batch;
		end

		// drain
		while (queued_requests.size() != 0 || req_valid) @(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("requests: %0d insert, %0d delete, %0d next, %0d prev; %0d results checked",
			kind_seen[KIND_INSERT], kind_seen[KIND_DELETE], kind_seen[KIND_NEXT],
			kind_seen[KIND_PREV], results_seen);
		$display("outcomes: %0d ok, %0d bad slot, %0d list full; most elements held %0d",
			status_seen[ST_OK], status_seen[ST_INVALID], status_seen[ST_FULL], peak_elems);
		if (mismatches == 0)
			$display("array_linked_list_engine verification clean");
		else
			$display("array_linked_list_engine verification failed");
		$finish;
	end

	// watchdog
	initial begin
		while (cycles_run < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles_run++;
		end
		$display("%0t: timeout after %0d cycles", $time, cycles_run);
		$display("array_linked_list_engine verification failed");
		$finish;
	end

endmodule

>>> array_linked_list_engine.f
+incdir+src
src/alle_pkg.sv
src/alle_ram.sv
src/alle_core.sv
src/array_linked_list_engine.sv
src/alle_checker.sv
tb/tb_array_linked_list_engine.sv
